// ----- rtl/multi_channel_switch_pulse_timer_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the switch pulse timer.
// Each macro checks one implication on the rising clock edge, outside reset.
// ----------------------------------------------------------------------------
`ifndef MULTI_CHANNEL_SWITCH_PULSE_TIMER_ASSERT_SVH
`define MULTI_CHANNEL_SWITCH_PULSE_TIMER_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication.
`define MCSPT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mcspt assertion failed");
// Next-cycle implication.
`define MCSPT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mcspt assertion failed");
`else
`define MCSPT_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define MCSPT_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ----- rtl/mcspt_pkg.sv -----
// ----------------------------------------------------------------------------
// mcspt_pkg
// Shared constants, codes and types of the switch pulse timer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mcspt_pkg;

  localparam int NUM_CH = 16;
  localparam int CH_W   = 4;
  localparam int DUR_W  = 32;
  localparam int CIU_W  = 5;
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  // Operation codes.
  localparam logic [2:0] OP_PULSE_TOGGLE  = 3'd0;
  localparam logic [2:0] OP_PULSE_RESTORE = 3'd1;
  localparam logic [2:0] OP_DELAYED_SET   = 3'd2;
  localparam logic [2:0] OP_CANCEL        = 3'd3;
  localparam logic [2:0] OP_QUERY         = 3'd4;
  localparam logic [2:0] OP_TICK          = 3'd5;

  // Result kinds.
  localparam logic [2:0] KIND_STARTED   = 3'd0;
  localparam logic [2:0] KIND_REJECTED  = 3'd1;
  localparam logic [2:0] KIND_CANCELLED = 3'd2;
  localparam logic [2:0] KIND_QUERY     = 3'd3;
  localparam logic [2:0] KIND_EXPIRED   = 3'd4;

  // Error codes.
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_CHANNEL  = 2'd1;
  localparam logic [1:0] ERR_DURATION = 2'd2;

  // Register indexes (word address).
  localparam logic [1:0] REG_MAX_DURATION    = 2'd0;
  localparam logic [1:0] REG_RESTORE_ENABLE  = 2'd1;
  localparam logic [1:0] REG_CHANNELS_IN_USE = 2'd2;

  localparam logic [DUR_W-1:0] MAX_DURATION_RST    = 32'd3600000;
  localparam logic             RESTORE_ENABLE_RST  = 1'b1;
  localparam logic [CIU_W-1:0] CHANNELS_IN_USE_RST = 5'd16;

  typedef struct packed {
    logic [DUR_W-1:0] max_duration;
    logic             restore_enable;
    logic [CIU_W-1:0] channels_in_use;
  } mcspt_cfg_t;

  typedef struct packed {
    logic accept;
    logic exec;
    logic walk;
    logic flush;
  } mcspt_cmd_t;

  typedef struct packed {
    logic exec_done;
    logic step_done;
    logic walk_end;
    logic flush_done;
    logic pend_valid;
  } mcspt_sts_t;

  typedef struct packed {
    logic [2:0]       kind;
    logic [CH_W-1:0]  chan_out;
    logic [1:0]       error_code;
    logic [DUR_W-1:0] remaining_ms;
    logic             is_active;
    logic             applied;
    logic             switch_level;
    logic             last;
  } mcspt_res_t;

endpackage

`default_nettype wire

// ----- rtl/multi_channel_switch_pulse_timer.sv -----
// ----------------------------------------------------------------------------
// multi_channel_switch_pulse_timer
// Bank of sixteen one-shot millisecond timers that drive switch levels.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake             Moves
//   in_      input      in_valid / in_ready   one request (op, channel, ...)
//   out_     output     out_valid / out_ready one result, out_last on the final
//   cfg      input      psel/penable/pwrite   register write, pready always 1
//
// A start, cancel or query request is accepted in IDLE and executed into the
// output register in EXEC, which waits while a result in the output is held.
// A tick request walks the channels one per cycle through a single shared
// decrement and compare, pausing while an expiry waits for a held result;
// each expiry is held in a pending slot until the next one or the end of the
// walk, so the final one can carry out_last.
// Reset is synchronous and active low and needs no clearing pass; the armed
// flags gate every stored count.
// in_ready is low while a request is in progress; a result waiting in the
// output register does not block the next request from being accepted.
`timescale 1ns / 1ps
`default_nettype none

`include "multi_channel_switch_pulse_timer_assert.svh"

module multi_channel_switch_pulse_timer
  import mcspt_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  // Request channel.
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [2:0]        in_op,
  input  wire logic [CH_W-1:0]   in_channel,
  input  wire logic [DUR_W-1:0]  in_duration_ms,
  input  wire logic              in_level,
  // Result channel.
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [2:0]             out_kind,
  output logic [CH_W-1:0]        out_chan_out,
  output logic [1:0]             out_error_code,
  output logic [DUR_W-1:0]       out_remaining_ms,
  output logic                   out_is_active,
  output logic                   out_applied,
  output logic                   out_switch_level,
  output logic                   out_last,
  // Configuration port.
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready
);

  mcspt_cfg_t cfg;
  mcspt_cmd_t cmd;
  mcspt_sts_t sts;
  mcspt_res_t res;

  // Register file: maximum duration, restore enable and channel count.
  mcspt_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // The controller decides what happens each cycle; it sees the request
  // opcode only to pick between command execution and a tick walk.
  mcspt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_op),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds all channel state and the output register.
  mcspt_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .cmd            (cmd),
    .sts            (sts),
    .in_op          (in_op),
    .in_channel     (in_channel),
    .in_duration_ms (in_duration_ms),
    .in_level       (in_level),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_res        (res)
  );

  assign out_kind         = res.kind;
  assign out_chan_out     = res.chan_out;
  assign out_error_code   = res.error_code;
  assign out_remaining_ms = res.remaining_ms;
  assign out_is_active    = res.is_active;
  assign out_applied      = res.applied;
  assign out_switch_level = res.switch_level;
  assign out_last         = res.last;

  // A tick walk keeps the request channel closed on the following cycle.
  `MCSPT_ASSERT_NXT(a_tick_blocks_input, clk, rst_n, in_valid && in_ready && in_op == OP_TICK, !in_ready)

  // A pending expiry only exists inside a tick walk, never while idle.
  `MCSPT_ASSERT_IMP(a_pend_not_idle, clk, rst_n, sts.pend_valid, !in_ready)

  // Only expiry results can come in a multi-result burst.
  `MCSPT_ASSERT_IMP(a_single_is_last, clk, rst_n, out_valid && out_kind != KIND_EXPIRED, out_last)

endmodule

`default_nettype wire

// ----- rtl/mcspt_regs.sv -----
// ----------------------------------------------------------------------------
// mcspt_regs
// Configuration registers behind the APB-style port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mcspt_regs
  import mcspt_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output mcspt_cfg_t             cfg
);

  mcspt_cfg_t cfg_r;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_duration    <= MAX_DURATION_RST;
      cfg_r.restore_enable  <= RESTORE_ENABLE_RST;
      cfg_r.channels_in_use <= CHANNELS_IN_USE_RST;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_MAX_DURATION:    cfg_r.max_duration    <= pwdata;
        REG_RESTORE_ENABLE:  cfg_r.restore_enable  <= pwdata[0];
        REG_CHANNELS_IN_USE: cfg_r.channels_in_use <= pwdata[CIU_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_MAX_DURATION:    prdata = cfg_r.max_duration;
      REG_RESTORE_ENABLE:  prdata = {{(DATA_W-1){1'b0}}, cfg_r.restore_enable};
      REG_CHANNELS_IN_USE: prdata = {{(DATA_W-CIU_W){1'b0}}, cfg_r.channels_in_use};
      default:             prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/mcspt_ctrl.sv -----
// ----------------------------------------------------------------------------
// mcspt_ctrl
// Controller: accepts requests and sequences command execution and tick walks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mcspt_ctrl
  import mcspt_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic [2:0] in_op,
  output logic            in_ready,
  input  wire mcspt_sts_t sts,
  output mcspt_cmd_t      cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_EXEC  = 2'd1;
  localparam logic [1:0] ST_WALK  = 2'd2;
  localparam logic [1:0] ST_FLUSH = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    cmd.accept = in_valid & in_ready;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.accept) begin
          unique case (in_op) inside
            OP_PULSE_TOGGLE, OP_PULSE_RESTORE, OP_DELAYED_SET, OP_CANCEL, OP_QUERY:
              state_nxt = ST_EXEC;
            OP_TICK:
              state_nxt = ST_WALK;
            default:
              state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.exec_done) state_nxt = ST_IDLE;
      end
      ST_WALK: begin
        cmd.walk = 1'b1;
        if (sts.step_done && sts.walk_end) state_nxt = ST_FLUSH;
      end
      ST_FLUSH: begin
        cmd.flush = 1'b1;
        if (sts.flush_done) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/mcspt_dp.sv -----
// ----------------------------------------------------------------------------
// mcspt_dp
// Datapath: per-channel timer state, switch levels, pending expiry, output
// register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mcspt_dp
  import mcspt_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire mcspt_cfg_t       cfg,
  input  wire mcspt_cmd_t       cmd,
  output mcspt_sts_t            sts,
  input  wire logic [2:0]       in_op,
  input  wire logic [CH_W-1:0]  in_channel,
  input  wire logic [DUR_W-1:0] in_duration_ms,
  input  wire logic             in_level,
  input  wire logic             out_ready,
  output logic                  out_valid,
  output mcspt_res_t            out_res
);

  // Latched request.
  logic [2:0]       req_op_r;
  logic [CH_W-1:0]  req_ch_r;
  logic [DUR_W-1:0] req_dur_r;
  logic             req_lvl_r;

  // Channel state. Counts are only meaningful while armed.
  logic [DUR_W-1:0]  cnt_r [NUM_CH];
  logic [NUM_CH-1:0] armed_r;
  logic [NUM_CH-1:0] exp_lvl_r;
  logic [NUM_CH-1:0] exp_app_r;
  logic [NUM_CH-1:0] delayed_r;
  logic [NUM_CH-1:0] lvl_r;

  // Tick walk.
  logic [CH_W-1:0] idx_r;
  logic            pend_vld_r;
  logic [CH_W-1:0] pend_ch_r;
  logic            pend_app_r;
  logic            pend_lvl_r;

  logic       out_vld_r;
  mcspt_res_t out_r;
  mcspt_res_t out_nxt;
  mcspt_res_t exec_res;

  logic             out_free;
  logic [DUR_W-1:0] w_cnt;
  logic [DUR_W-1:0] w_dec;
  logic             w_exp;
  logic             w_app;
  logic             w_lvl_new;
  logic             step_ok;
  logic             walk_fire;
  logic             walk_push;
  logic             walk_end;
  logic             flush_fire;
  logic             exec_fire;
  logic             out_load;
  logic             e_cur;
  logic             e_start;
  logic             e_ok;
  logic             bad_ch;
  logic             bad_dur;
  logic             start_fire;

  assign out_free = ~out_vld_r | out_ready;

  // One channel per cycle during a tick, unless an expiry waits for the output.
  assign w_cnt     = cnt_r[idx_r];
  assign w_dec     = w_cnt - {{(DUR_W-1){1'b0}}, |w_cnt};
  assign w_exp     = armed_r[idx_r] & (w_dec == '0);
  assign w_app     = delayed_r[idx_r] | (exp_app_r[idx_r] & cfg.restore_enable);
  assign w_lvl_new = w_app ? exp_lvl_r[idx_r] : lvl_r[idx_r];
  assign walk_end  = (idx_r == CH_W'(NUM_CH - 1));

  // An expiry that finds an earlier one still pending must push it out first.
  assign step_ok    = ~(w_exp & pend_vld_r & ~out_free);
  assign walk_fire  = cmd.walk & step_ok;
  assign walk_push  = walk_fire & w_exp & pend_vld_r;
  assign flush_fire = cmd.flush & pend_vld_r & out_free;

  // Command execution.
  assign exec_fire  = cmd.exec & out_free;
  assign e_cur      = lvl_r[req_ch_r];
  assign e_start    = (req_op_r == OP_PULSE_TOGGLE) | (req_op_r == OP_PULSE_RESTORE) |
                      (req_op_r == OP_DELAYED_SET);
  assign bad_ch     = ({1'b0, req_ch_r} >= cfg.channels_in_use);
  assign bad_dur    = (req_dur_r == '0) | (req_dur_r > cfg.max_duration);
  assign e_ok       = ~bad_ch & ~bad_dur;
  assign start_fire = exec_fire & e_start & e_ok;

  always_comb begin
    exec_res          = '0;
    exec_res.chan_out = req_ch_r;
    exec_res.last     = 1'b1;
    exec_res.switch_level = e_cur;
    if (e_start) begin
      if (bad_ch) begin
        exec_res.kind       = KIND_REJECTED;
        exec_res.error_code = ERR_CHANNEL;
      end else if (bad_dur) begin
        exec_res.kind       = KIND_REJECTED;
        exec_res.error_code = ERR_DURATION;
      end else begin
        exec_res.kind         = KIND_STARTED;
        exec_res.switch_level = (req_op_r == OP_DELAYED_SET) ? e_cur : ~e_cur;
      end
    end else begin
      exec_res.kind         = (req_op_r == OP_CANCEL) ? KIND_CANCELLED : KIND_QUERY;
      exec_res.is_active    = armed_r[req_ch_r];
      exec_res.remaining_ms = armed_r[req_ch_r] ? cnt_r[req_ch_r] : '0;
    end
  end

  assign out_load = exec_fire | walk_push | flush_fire;

  always_comb begin
    if (exec_fire) begin
      out_nxt = exec_res;
    end else begin
      out_nxt              = '0;
      out_nxt.kind         = KIND_EXPIRED;
      out_nxt.chan_out     = pend_ch_r;
      out_nxt.error_code   = ERR_NONE;
      out_nxt.applied      = pend_app_r;
      out_nxt.switch_level = pend_lvl_r;
      out_nxt.last         = flush_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r    <= '0;
      lvl_r      <= '0;
      idx_r      <= '0;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      if (out_load) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
      if (start_fire) begin
        armed_r[req_ch_r] <= 1'b1;
        if (req_op_r != OP_DELAYED_SET) lvl_r[req_ch_r] <= ~e_cur;
      end else if (exec_fire && req_op_r == OP_CANCEL) begin
        armed_r[req_ch_r] <= 1'b0;
      end
      if (walk_fire) begin
        if (w_exp) begin
          armed_r[idx_r] <= 1'b0;
          lvl_r[idx_r]   <= w_lvl_new;
          pend_vld_r     <= 1'b1;
        end
        idx_r <= walk_end ? '0 : idx_r + 1'b1;
      end
      if (flush_fire) pend_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_op_r  <= in_op;
      req_ch_r  <= in_channel;
      req_dur_r <= in_duration_ms;
      req_lvl_r <= in_level;
    end
    if (start_fire) begin
      cnt_r[req_ch_r]     <= req_dur_r;
      exp_lvl_r[req_ch_r] <= (req_op_r == OP_PULSE_TOGGLE) ? e_cur : req_lvl_r;
      exp_app_r[req_ch_r] <= (req_op_r == OP_DELAYED_SET) ? 1'b1 : cfg.restore_enable;
      delayed_r[req_ch_r] <= (req_op_r == OP_DELAYED_SET);
    end
    if (walk_fire && armed_r[idx_r]) cnt_r[idx_r] <= w_dec;
    if (walk_fire && w_exp) begin
      pend_ch_r  <= idx_r;
      pend_app_r <= w_app;
      pend_lvl_r <= w_lvl_new;
    end
    if (out_load) out_r <= out_nxt;
  end

  assign sts.exec_done  = out_free;
  assign sts.step_done  = step_ok;
  assign sts.walk_end   = walk_end;
  assign sts.flush_done = ~pend_vld_r | out_free;
  assign sts.pend_valid = pend_vld_r;

  assign out_valid = out_vld_r;
  assign out_res   = out_r;

endmodule

`default_nettype wire
